### src/aabb_affine_transform_assert.svh
// assertion macros for the transformed bounding box block
`ifndef AABB_AFFINE_TRANSFORM_ASSERT_SVH
`define AABB_AFFINE_TRANSFORM_ASSERT_SVH

// same-cycle implication, checked outside reset
`define AAT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("aat check failed");

// next-cycle implication, checked outside reset
`define AAT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("aat check failed");

`endif

### src/aat_pkg.sv
// shared types, constants and helpers for the transformed bounding box block
package aat_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int PROD_W    = 2 * DATA_W - FRAC_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int CFG_IDX_W = 3;
    localparam int STAGES    = 4;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OBJ_MIN_X = 3'd0,
        REG_OBJ_MIN_Y = 3'd1,
        REG_OBJ_MIN_Z = 3'd2,
        REG_OBJ_MAX_X = 3'd3,
        REG_OBJ_MAX_Y = 3'd4,
        REG_OBJ_MAX_Z = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic signed [DATA_W-1:0] m00;
        logic signed [DATA_W-1:0] m01;
        logic signed [DATA_W-1:0] m02;
        logic signed [DATA_W-1:0] m03;
        logic signed [DATA_W-1:0] m10;
        logic signed [DATA_W-1:0] m11;
        logic signed [DATA_W-1:0] m12;
        logic signed [DATA_W-1:0] m13;
        logic signed [DATA_W-1:0] m20;
        logic signed [DATA_W-1:0] m21;
        logic signed [DATA_W-1:0] m22;
        logic signed [DATA_W-1:0] m23;
    } t_aat_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] world_min_x;
        logic signed [DATA_W-1:0] world_min_y;
        logic signed [DATA_W-1:0] world_min_z;
        logic signed [DATA_W-1:0] world_max_x;
        logic signed [DATA_W-1:0] world_max_y;
        logic signed [DATA_W-1:0] world_max_z;
        logic signed [DATA_W-1:0] center_x;
        logic signed [DATA_W-1:0] center_y;
        logic signed [DATA_W-1:0] center_z;
        logic signed [DATA_W-1:0] half_x;
        logic signed [DATA_W-1:0] half_y;
        logic signed [DATA_W-1:0] half_z;
    } t_aat_out;

    // object box as seen by the row datapaths
    typedef struct packed {
        logic signed [DATA_W-1:0] min_x;
        logic signed [DATA_W-1:0] min_y;
        logic signed [DATA_W-1:0] min_z;
        logic signed [DATA_W-1:0] max_x;
        logic signed [DATA_W-1:0] max_y;
        logic signed [DATA_W-1:0] max_z;
    } t_aat_box;

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-64'sd2147483648);

    // clamp a wide sum to the signed 32-bit range
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [DATA_W-1:0] res;
        if (v > SAT_HI) begin
            res = SAT_HI[DATA_W-1:0];
        end else if (v < SAT_LO) begin
            res = SAT_LO[DATA_W-1:0];
        end else begin
            res = v[DATA_W-1:0];
        end
        return res;
    endfunction

endpackage

### src/aat_cfg.sv
// object box configuration registers
module aat_cfg
    import aat_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data,
    output t_aat_box             o_box
);

    t_aat_box r_box;

    // register write decode, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_OBJ_MIN_X: r_box.min_x <= i_cfg_data;
                REG_OBJ_MIN_Y: r_box.min_y <= i_cfg_data;
                REG_OBJ_MIN_Z: r_box.min_z <= i_cfg_data;
                REG_OBJ_MAX_X: r_box.max_x <= i_cfg_data;
                REG_OBJ_MAX_Y: r_box.max_y <= i_cfg_data;
                REG_OBJ_MAX_Z: r_box.max_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_box = r_box;

endmodule

### src/aat_row.sv
// four-stage datapath for one matrix row: products, sort, sum, center and half
module aat_row
    import aat_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [DATA_W-1:0] i_m [4],
    input  logic signed [DATA_W-1:0] i_bmin [3],
    input  logic signed [DATA_W-1:0] i_bmax [3],
    output logic signed [DATA_W-1:0] o_min,
    output logic signed [DATA_W-1:0] o_max,
    output logic signed [DATA_W-1:0] o_center,
    output logic signed [DATA_W-1:0] o_half
);

    logic signed [2*DATA_W-1:0] prod_a [3];
    logic signed [2*DATA_W-1:0] prod_b [3];
    logic signed [PROD_W-1:0]   r_pa [3];
    logic signed [PROD_W-1:0]   r_pb [3];
    logic signed [PROD_W-1:0]   r_lo [3];
    logic signed [PROD_W-1:0]   r_hi [3];
    logic signed [DATA_W-1:0]   r_t1;
    logic signed [DATA_W-1:0]   r_t2;
    logic signed [SUM_W-1:0]    sum_lo;
    logic signed [SUM_W-1:0]    sum_hi;
    logic signed [DATA_W-1:0]   r_wmin;
    logic signed [DATA_W-1:0]   r_wmax;
    logic signed [DATA_W:0]     n_csum;
    logic signed [DATA_W:0]     n_hdif;
    logic signed [DATA_W-1:0]   r_min;
    logic signed [DATA_W-1:0]   r_max;
    logic signed [DATA_W-1:0]   r_center;
    logic signed [DATA_W-1:0]   r_half;

    // column products against both box bounds
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            prod_a[c] = (2*DATA_W)'(i_m[c]) * (2*DATA_W)'(i_bmin[c]);
            prod_b[c] = (2*DATA_W)'(i_m[c]) * (2*DATA_W)'(i_bmax[c]);
        end
    end

    // stage 1: products shifted down to q32.16
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r_pa[c] <= prod_a[c][2*DATA_W-1:FRAC_W];
                r_pb[c] <= prod_b[c][2*DATA_W-1:FRAC_W];
            end
            r_t1 <= i_m[3];
        end
    end

    // stage 2: pick the smaller and larger product per column
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                if (r_pa[c] < r_pb[c]) begin
                    r_lo[c] <= r_pa[c];
                    r_hi[c] <= r_pb[c];
                end else begin
                    r_lo[c] <= r_pb[c];
                    r_hi[c] <= r_pa[c];
                end
            end
            r_t2 <= r_t1;
        end
    end

    // exact row sums plus translation
    assign sum_lo = SUM_W'(r_lo[0]) + SUM_W'(r_lo[1]) + SUM_W'(r_lo[2]) + SUM_W'(r_t2);
    assign sum_hi = SUM_W'(r_hi[0]) + SUM_W'(r_hi[1]) + SUM_W'(r_hi[2]) + SUM_W'(r_t2);

    // stage 3: saturated world bounds
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wmin <= sat32(sum_lo);
            r_wmax <= sat32(sum_hi);
        end
    end

    // 33-bit sum and difference, halved by dropping the low bit
    assign n_csum = (DATA_W+1)'(r_wmin) + (DATA_W+1)'(r_wmax);
    assign n_hdif = (DATA_W+1)'(r_wmax) - (DATA_W+1)'(r_wmin);

    // stage 4: result register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_min    <= r_wmin;
            r_max    <= r_wmax;
            r_center <= n_csum[DATA_W:1];
            r_half   <= n_hdif[DATA_W:1];
        end
    end

    assign o_min    = r_min;
    assign o_max    = r_max;
    assign o_center = r_center;
    assign o_half   = r_half;

endmodule

### src/aabb_affine_transform.sv
// top level of the transformed axis-aligned bounding box block
//
//  channel   valid        ready        payload
//  -------   ----------   ----------   ------------------------
//  input     i_in_valid   o_in_ready   i_in_data   (t_aat_in)
//  output    o_out_valid  i_out_ready  o_out_data  (t_aat_out)
//  config    i_cfg_valid  o_cfg_ready  i_cfg_index, i_cfg_data
//
//  one item per cycle unless the output stalls; output valid rises once an input has passed every stage
//  the stages are: multiply, min/max sort, sum and saturate, center/half register
//  the pipeline advances as a whole whenever the output register is empty or drained
//  a stall at the output freezes every stage, so nothing is lost or repeated
//  synchronous reset clears the valid bits and the box registers to zero
module aabb_affine_transform
    import aat_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_aat_in              i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_aat_out             o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data
);

    t_aat_box                 box;
    logic                     adv;
    logic [STAGES-1:0]        r_vld;
    logic signed [DATA_W-1:0] bmin [3];
    logic signed [DATA_W-1:0] bmax [3];
    logic signed [DATA_W-1:0] row_m [3][4];
    logic signed [DATA_W-1:0] w_min [3];
    logic signed [DATA_W-1:0] w_max [3];
    logic signed [DATA_W-1:0] w_ctr [3];
    logic signed [DATA_W-1:0] w_half [3];

    // configuration registers, always ready
    aat_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_box       (box)
    );
    assign o_cfg_ready = 1'b1;

    // pipeline advance and valid bits
    assign adv        = !r_vld[STAGES-1] || i_out_ready;
    assign o_in_ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[STAGES-2:0], i_in_valid};
        end
    end

    // unpack box and matrix rows
    assign bmin = '{box.min_x, box.min_y, box.min_z};
    assign bmax = '{box.max_x, box.max_y, box.max_z};
    assign row_m[0] = '{i_in_data.m00, i_in_data.m01, i_in_data.m02, i_in_data.m03};
    assign row_m[1] = '{i_in_data.m10, i_in_data.m11, i_in_data.m12, i_in_data.m13};
    assign row_m[2] = '{i_in_data.m20, i_in_data.m21, i_in_data.m22, i_in_data.m23};

    // one datapath per world axis
    for (genvar r = 0; r < 3; r++) begin : g_row
        aat_row u_row (
            .i_clk    (i_clk),
            .i_en     (adv),
            .i_m      (row_m[r]),
            .i_bmin   (bmin),
            .i_bmax   (bmax),
            .o_min    (w_min[r]),
            .o_max    (w_max[r]),
            .o_center (w_ctr[r]),
            .o_half   (w_half[r])
        );
    end

    // result transfer
    assign o_out_valid = r_vld[STAGES-1];

    always_comb begin
        o_out_data.world_min_x = w_min[0];
        o_out_data.world_min_y = w_min[1];
        o_out_data.world_min_z = w_min[2];
        o_out_data.world_max_x = w_max[0];
        o_out_data.world_max_y = w_max[1];
        o_out_data.world_max_z = w_max[2];
        o_out_data.center_x    = w_ctr[0];
        o_out_data.center_y    = w_ctr[1];
        o_out_data.center_z    = w_ctr[2];
        o_out_data.half_x      = w_half[0];
        o_out_data.half_y      = w_half[1];
        o_out_data.half_z      = w_half[2];
    end

endmodule

### src/aat_check.sv
// port-level checker for the transformed bounding box block, with its bind
`include "aabb_affine_transform_assert.svh"

module aat_check
    import aat_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     o_in_ready,
    input logic     o_out_valid,
    input logic     i_out_ready,
    input t_aat_out o_out_data
);

    // a stalled result holds
    `AAT_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))

    // input side only stalls behind a full output register
    `AAT_ASSERT_NOW(a_in_ready, !o_out_valid, o_in_ready)

    // half lengths are never negative
    `AAT_ASSERT_NOW(a_half_pos, o_out_valid, !o_out_data.half_x[DATA_W-1] && !o_out_data.half_y[DATA_W-1] && !o_out_data.half_z[DATA_W-1])

    // world minimum never exceeds maximum
    `AAT_ASSERT_NOW(a_min_max, o_out_valid, (o_out_data.world_min_x <= o_out_data.world_max_x) && (o_out_data.world_min_y <= o_out_data.world_max_y) && (o_out_data.world_min_z <= o_out_data.world_max_z))

endmodule

bind aabb_affine_transform aat_check u_aat_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

### tb/tb_aabb_affine_transform.sv
// self-checking testbench for the transformed axis-aligned bounding box block
module tb_aabb_affine_transform;
    import aat_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD      = 10;
    localparam int NUM_BOX_REGS    = 6;
    localparam int NUM_FIELDS      = 12;
    localparam int RAND_PHASES     = 7;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int COEF_SPAN       = 20;  // about +-8.0 in Q16.16
    localparam int COORD_SPAN      = 27;  // about +-1024.0 in Q16.16

    localparam logic [DATA_W-1:0] QMAX  = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] QMIN  = 32'h8000_0000;
    localparam logic [DATA_W-1:0] ONE   = 32'h0001_0000;
    localparam logic [DATA_W-1:0] M_ONE = 32'hFFFF_0000;

    localparam longint Q_HI = 64'sd2147483647;
    localparam longint Q_LO = -64'sd2147483648;

    typedef logic [DATA_W-1:0] t_box_vals [NUM_BOX_REGS];

    // predicted world bounds and their comparison against the block
    class bounds_scoreboard;
        // box registers come out of reset as zero
        logic signed [DATA_W-1:0] box [NUM_BOX_REGS] = '{default: '0};
        t_aat_out bounds_q [$];
        int n_errors;
        string field_names [NUM_FIELDS] = '{
            "world_min_x", "world_min_y", "world_min_z",
            "world_max_x", "world_max_y", "world_max_z",
            "center_x", "center_y", "center_z",
            "half_x", "half_y", "half_z"};

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
            // indexes past the box registers are dropped
            if (idx < NUM_BOX_REGS) begin
                box[idx] = val;
            end
        endfunction

        function longint clamp32(longint v);
            if (v > Q_HI) begin
                return Q_HI;
            end else if (v < Q_LO) begin
                return Q_LO;
            end
            return v;
        endfunction

        // per row: pick the smaller and larger product per column, add translation
        function t_aat_out transform_bounds(t_aat_in mat);
            logic signed [DATA_W-1:0] coef [3][4];
            logic [DATA_W-1:0] field [NUM_FIELDS];
            longint lo_sum, hi_sum, pa, pb, wmin, wmax;
            t_aat_out res;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 4; c++) begin
                    coef[r][c] = mat[(NUM_FIELDS - 1 - (r * 4 + c)) * DATA_W +: DATA_W];
                end
                lo_sum = longint'(coef[r][3]);
                hi_sum = longint'(coef[r][3]);
                for (int c = 0; c < 3; c++) begin
                    // products truncate toward minus infinity
                    pa = (longint'(coef[r][c]) * longint'(box[c])) >>> FRAC_W;
                    pb = (longint'(coef[r][c]) * longint'(box[c + 3])) >>> FRAC_W;
                    if (pa < pb) begin
                        lo_sum += pa;
                        hi_sum += pb;
                    end else begin
                        lo_sum += pb;
                        hi_sum += pa;
                    end
                end
                wmin = clamp32(lo_sum);
                wmax = clamp32(hi_sum);
                field[r]     = wmin[DATA_W-1:0];
                field[3 + r] = wmax[DATA_W-1:0];
                field[6 + r] = DATA_W'((wmin + wmax) >>> 1);
                field[9 + r] = DATA_W'((wmax - wmin) >>> 1);
            end
            for (int k = 0; k < NUM_FIELDS; k++) begin
                res[(NUM_FIELDS - 1 - k) * DATA_W +: DATA_W] = field[k];
            end
            return res;
        endfunction

        function void note_matrix(t_aat_in mat);
            bounds_q.push_back(transform_bounds(mat));
        endfunction

        function void check_result(t_aat_out got);
            t_aat_out want;
            logic signed [DATA_W-1:0] w, g;
            if (bounds_q.size() == 0) begin
                $error("result with no transform outstanding: %h", got);
                n_errors++;
                return;
            end
            want = bounds_q.pop_front();
            for (int k = 0; k < NUM_FIELDS; k++) begin
                w = want[(NUM_FIELDS - 1 - k) * DATA_W +: DATA_W];
                g = got[(NUM_FIELDS - 1 - k) * DATA_W +: DATA_W];
                if (w !== g) begin
                    $error("%s: expected %0d, got %0d", field_names[k], w, g);
                    n_errors++;
                end
            end
        endfunction
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    t_aat_in              i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_aat_out             o_out_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [DATA_W-1:0]    i_cfg_data  = '0;

    bounds_scoreboard sb;
    bit idle_on = 1'b1;
    int ready_hold = 0;

    aabb_affine_transform dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // output back-pressure in random bursts
    always @(negedge i_clk) begin
        if (!idle_on) begin
            i_out_ready <= 1'b1;
            ready_hold  <= 0;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            i_out_ready <= 1'b0;
            ready_hold  <= $urandom_range(0, 17);
        end else begin
            i_out_ready <= 1'b1;
            ready_hold  <= $urandom_range(0, 29);
        end
    end

    // check every result transfer
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_out_data);
        end
    end

    // Q16.16 value: mostly in a span, sometimes full range or an extreme
    function automatic logic [DATA_W-1:0] rand_q16(input int span_bits);
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 5))
                    0: v = QMAX;
                    1: v = QMIN;
                    2: v = ONE;
                    3: v = M_ONE;
                    4: v = '1;
                    default: v = '0;
                endcase
            end
            1, 2: v = $urandom;
            default: v = $urandom_range(0, 1 << span_bits) - (1 << (span_bits - 1));
        endcase
        return v;
    endfunction

    function automatic t_aat_in rand_matrix();
        t_aat_in mat;
        for (int k = 0; k < NUM_FIELDS; k++) begin
            mat[k * DATA_W +: DATA_W] = rand_q16(COEF_SPAN);
        end
        return mat;
    endfunction

    // one matrix transfer, with an occasional idle burst ahead of it
    task automatic send_matrix(input t_aat_in mat);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= mat;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_matrix(mat);
        @(negedge i_clk);
    endtask

    // stop sending and let the pipeline empty
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.bounds_q.size() != 0) @(negedge i_clk);
        repeat (STAGES + 2) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, val);
        @(negedge i_clk);
    endtask

    // reprogram the object box once idle, plus a write to an unused index
    task automatic load_box(input t_box_vals vals);
        wait_drained();
        for (int i = 0; i < NUM_BOX_REGS; i++) begin
            write_reg(CFG_IDX_W'(i), vals[i]);
        end
        write_reg(CFG_IDX_W'($urandom_range(NUM_BOX_REGS, (1 << CFG_IDX_W) - 1)), $urandom);
        i_cfg_valid <= 1'b0;
    endtask

    // stimulus
    initial begin : stimulus
        t_box_vals vals;
        t_aat_in mat;
        sb = new();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // zero box out of reset: only translation survives
        send_matrix({NUM_FIELDS{QMAX}});
        send_matrix({NUM_FIELDS{QMIN}});

        // small box around the origin: min (-1.5, -2, -3.25), max (1, 2.5, 3)
        vals = '{32'hFFFE_8000, 32'hFFFE_0000, 32'hFFFC_C000,
                 32'h0001_0000, 32'h0002_8000, 32'h0003_0000};
        load_box(vals);
        mat = '{ONE, 0, 0, 0,  0, ONE, 0, 0,  0, 0, ONE, 0};
        send_matrix(mat);
        // identity with translation (10, -20, 0.5)
        mat = '{ONE, 0, 0, 32'h000A_0000,  0, ONE, 0, 32'hFFEC_0000,  0, 0, ONE, 32'h0000_8000};
        send_matrix(mat);
        mat = '{M_ONE, 0, 0, 0,  0, M_ONE, 0, 0,  0, 0, M_ONE, 0};
        send_matrix(mat);
        // quarter turn about z
        mat = '{0, M_ONE, 0, ONE,  ONE, 0, 0, M_ONE,  0, 0, ONE, 0};
        send_matrix(mat);
        // lsb coefficients: products round toward minus infinity, odd center sums
        mat = '{'1, '1, '1, 1,  1, 1, 1, '1,  '1, 1, '1, 1};
        send_matrix(mat);
        // translation at the rails forces saturation both ways
        mat = '{ONE, 0, 0, QMAX,  0, ONE, 0, QMIN,  0, 0, ONE, QMAX};
        send_matrix(mat);
        mat = '{ONE, 0, 0, QMIN,  0, ONE, 0, QMAX,  0, 0, ONE, QMIN};
        send_matrix(mat);
        send_matrix({NUM_FIELDS{QMAX}});
        send_matrix({NUM_FIELDS{QMIN}});

        // full-range box
        vals = '{QMIN, QMIN, QMIN, QMAX, QMAX, QMAX};
        load_box(vals);
        mat = '{ONE, 0, 0, 0,  0, ONE, 0, 0,  0, 0, ONE, 0};
        send_matrix(mat);
        send_matrix({NUM_FIELDS{QMAX}});
        send_matrix({NUM_FIELDS{QMIN}});
        send_matrix({NUM_FIELDS{32'hFFFF_FFFF}});
        mat = '{0, 0, 0, QMAX,  0, 0, 0, QMIN,  0, 0, 0, '1};
        send_matrix(mat);
        send_matrix(rand_matrix());

        // inverted box: min (2, 3, 4) above max (-2, -1, 0)
        vals = '{32'h0002_0000, 32'h0003_0000, 32'h0004_0000,
                 32'hFFFE_0000, 32'hFFFF_0000, 32'h0000_0000};
        load_box(vals);
        mat = '{ONE, 0, 0, 32'h0000_8000,  0, ONE, 0, '1,  0, 0, ONE, 1};
        send_matrix(mat);
        send_matrix({NUM_FIELDS{M_ONE}});
        send_matrix(rand_matrix());

        // random boxes and matrices, no idling in the last phase
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            for (int i = 0; i < NUM_BOX_REGS; i++) begin
                vals[i] = rand_q16(COORD_SPAN);
            end
            load_box(vals);
            idle_on = (ph != RAND_PHASES - 1);
            repeat (ITEMS_PER_PHASE) send_matrix(rand_matrix());
        end

        wait_drained();
        if (sb.n_errors == 0 && sb.bounds_q.size() == 0) begin
            $display("aabb_affine_transform: match");
        end else begin
            $display("aabb_affine_transform: mismatch");
        end
        $finish;
    end

    // run limit
    initial begin : watchdog
        #5ms;
        $display("aabb_affine_transform: mismatch");
        $finish;
    end

endmodule
